// ===== rtl/core/ffa_pkg.sv =====
// Shared types and constants for the first-fit free-list allocator.
// Holds the transfer payload structs, status codes and controller states.
// Depends on nothing; ffa_ctrl and the top level import it.
`default_nettype none

package ffa_pkg;

    // Fixed field widths of the transfer payloads.
    localparam int SIZE_W = 22;
    localparam int ADDR_W = 22;
    localparam int STAT_W = 2;
    localparam int CFG_W  = 23;
    localparam int NEED_W = 24;

    // Layout constants of the arena and of each chunk.
    localparam int ARENA_HDR   = 32;
    localparam int CHUNK_HDR   = 8;
    localparam int SPLIT_MIN   = 88;
    localparam int ARENA_MIN   = 128;
    localparam int ARENA_RESET = 4 * 1024 * 1024;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOFIT   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_UNKNOWN = 2'd3;

    // Request type codes.
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [SIZE_W-1:0] req_size;
        logic [ADDR_W-1:0] free_addr;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] result_addr;
        logic [STAT_W-1:0] status;
    } rsp_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_USCAN,
        S_FSCAN,
        S_FINS,
        S_SHUP,
        S_INS,
        S_UVSCAN,
        S_ACOM,
        S_SHDN,
        S_AFIN,
        S_DONE
    } ffa_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/ffa_ram.sv =====
// Simple dual-port synchronous RAM with one write and one registered read port.
// Holds either the free segment table or the used chunk table.
// Depends on nothing.
`default_nettype none

module ffa_ram #(
    parameter int DEPTH = 64,
    parameter int DW    = 45
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DW-1:0]            wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [DW-1:0]            rdata
);

    logic [DW-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/ffa_ctrl.sv =====
// Sequencer of the allocator: walks the tables, shifts segments and builds results.
// Depends on ffa_pkg; drives the two ffa_ram instances from the top level.
`default_nettype none

module ffa_ctrl #(
    parameter int FREE_SLOTS = 64,
    parameter int USED_SLOTS = 64,
    parameter int ADDR_BITS  = 22
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [ADDR_BITS:0]                  arena,
    input  wire logic                                req_valid,
    output logic                                     req_stall,
    input  wire ffa_pkg::req_t                       req,
    output logic                                     rsp_valid,
    input  wire logic                                rsp_stall,
    output ffa_pkg::rsp_t                            rsp,
    output logic                                     f_we,
    output logic [$clog2(FREE_SLOTS)-1:0]            f_waddr,
    output logic [2*ADDR_BITS:0]                     f_wdata,
    output logic [$clog2(FREE_SLOTS)-1:0]            f_raddr,
    input  wire logic [2*ADDR_BITS:0]                f_rdata,
    output logic                                     u_we,
    output logic [$clog2(USED_SLOTS)-1:0]            u_waddr,
    output logic [2*ADDR_BITS:0]                     u_wdata,
    output logic [$clog2(USED_SLOTS)-1:0]            u_raddr,
    input  wire logic [2*ADDR_BITS:0]                u_rdata
);

    import ffa_pkg::*;

    localparam int SW  = ADDR_BITS + 1;
    localparam int CW  = ((SW > NEED_W) ? SW : NEED_W) + 1;
    localparam int FIW = $clog2(FREE_SLOTS);
    localparam int FCW = $clog2(FREE_SLOTS + 1);
    localparam int UIW = $clog2(USED_SLOTS);
    localparam int UCW = $clog2(USED_SLOTS + 1);

    ffa_state_t              state_reg, state_next;
    logic [FCW-1:0]          fcnt_reg, fcnt_next;
    logic [USED_SLOTS-1:0]   uvalid_reg;
    logic [FCW-1:0]          fidx_reg, fidx_next;
    logic [FIW-1:0]          fcur_reg, fcur_next;
    logic [UCW-1:0]          uidx_reg, uidx_next;
    logic [UIW-1:0]          ucur_reg, ucur_next;
    logic                    vld_reg, vld_next;
    logic                    op_reg, op_next;
    logic [NEED_W-1:0]       need_reg, need_next;
    logic [ADDR_W-1:0]       fa_reg, fa_next;
    logic [FCW-1:0]          seg_idx_reg, seg_idx_next;
    logic [ADDR_BITS-1:0]    seg_start_reg, seg_start_next;
    logic [SW-1:0]           seg_size_reg, seg_size_next;
    logic [ADDR_BITS-1:0]    ch_start_reg, ch_start_next;
    logic [SW-1:0]           ch_size_reg, ch_size_next;
    logic [UIW-1:0]          uslot_reg, uslot_next;
    logic [FCW-1:0]          sidx_reg, sidx_next;
    logic [FIW-1:0]          wtgt_reg, wtgt_next;
    logic                    wpend_reg, wpend_next;
    rsp_t                    res_reg, res_next;
    rsp_t                    rsp_reg, rsp_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    logic                    set_v, clr_v;

    // Fields of the entries read back from the two tables.
    logic [CW-1:0] d_start, d_size, d_end, u_start, ch_end, left;
    logic [FCW-1:0] sidx_dec, sidx_inc;

    assign d_start  = CW'(f_rdata[2*ADDR_BITS:SW]);
    assign d_size   = CW'(f_rdata[SW-1:0]);
    assign d_end    = d_start + d_size;
    assign u_start  = CW'(u_rdata[2*ADDR_BITS:SW]);
    assign ch_end   = CW'(ch_start_reg) + CW'(ch_size_reg);
    assign left     = CW'(seg_size_reg) - CW'(need_reg);
    assign sidx_dec = sidx_reg - FCW'(1);
    assign sidx_inc = sidx_reg + FCW'(1);

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // State register and control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            fcnt_reg      <= FCW'(1);
            uvalid_reg    <= '0;
            vld_reg       <= 1'b0;
            wpend_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fcnt_reg      <= fcnt_next;
            vld_reg       <= vld_next;
            wpend_reg     <= wpend_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                uvalid_reg <= '0;
            end
            else if (set_v)
            begin
                uvalid_reg[uslot_reg] <= 1'b1;
            end
            else if (clr_v)
            begin
                uvalid_reg[uslot_reg] <= 1'b0;
            end
        end
    end

    // Working registers of the request in flight.
    always_ff @(posedge clk)
    begin
        fidx_reg      <= fidx_next;
        fcur_reg      <= fcur_next;
        uidx_reg      <= uidx_next;
        ucur_reg      <= ucur_next;
        op_reg        <= op_next;
        need_reg      <= need_next;
        fa_reg        <= fa_next;
        seg_idx_reg   <= seg_idx_next;
        seg_start_reg <= seg_start_next;
        seg_size_reg  <= seg_size_next;
        ch_start_reg  <= ch_start_next;
        ch_size_reg   <= ch_size_next;
        uslot_reg     <= uslot_next;
        sidx_reg      <= sidx_next;
        wtgt_reg      <= wtgt_next;
        res_reg       <= res_next;
        rsp_reg       <= rsp_next;
    end

    // Next state, table accesses and result assembly.
    always_comb
    begin
        state_next     = state_reg;
        fcnt_next      = fcnt_reg;
        fidx_next      = fidx_reg;
        fcur_next      = fcur_reg;
        uidx_next      = uidx_reg;
        ucur_next      = ucur_reg;
        vld_next       = vld_reg;
        op_next        = op_reg;
        need_next      = need_reg;
        fa_next        = fa_reg;
        seg_idx_next   = seg_idx_reg;
        seg_start_next = seg_start_reg;
        seg_size_next  = seg_size_reg;
        ch_start_next  = ch_start_reg;
        ch_size_next   = ch_size_reg;
        uslot_next     = uslot_reg;
        sidx_next      = sidx_reg;
        wtgt_next      = wtgt_reg;
        wpend_next     = wpend_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        set_v          = 1'b0;
        clr_v          = 1'b0;
        f_we           = 1'b0;
        f_waddr        = wtgt_reg;
        f_wdata        = f_rdata;
        f_raddr        = fidx_reg[FIW-1:0];
        u_we           = 1'b0;
        u_waddr        = uslot_reg;
        u_wdata        = {ch_start_reg, ch_size_reg};
        u_raddr        = uidx_reg[UIW-1:0];

        case (state_reg)
            // Seed the table with the single free segment after the header.
            S_INIT:
            begin
                f_we       = 1'b1;
                f_waddr    = '0;
                f_wdata    = {ADDR_BITS'(ARENA_HDR), arena - SW'(ARENA_HDR)};
                state_next = S_IDLE;
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = req.req_type;
                    need_next  = ((NEED_W'(req.req_size) + NEED_W'(7)) & ~NEED_W'(7))
                                 + NEED_W'(CHUNK_HDR);
                    fa_next    = req.free_addr;
                    vld_next   = 1'b0;
                    fidx_next  = '0;
                    uidx_next  = '0;
                    state_next = (req.req_type == REQ_FREE) ? S_USCAN : S_FSCAN;
                end
            end

            // Look the freed address up in the used table, one entry a cycle.
            S_USCAN:
            begin
                vld_next  = (uidx_reg < UCW'(USED_SLOTS));
                ucur_next = uidx_reg[UIW-1:0];
                if (uidx_reg < UCW'(USED_SLOTS))
                begin
                    uidx_next = uidx_reg + UCW'(1);
                end
                if (vld_reg)
                begin
                    if (uvalid_reg[ucur_reg]
                        && (u_start + CW'(CHUNK_HDR) == CW'(fa_reg)))
                    begin
                        ch_start_next = u_rdata[2*ADDR_BITS:SW];
                        ch_size_next  = u_rdata[SW-1:0];
                        uslot_next    = ucur_reg;
                        fidx_next     = '0;
                        vld_next      = 1'b0;
                        state_next    = S_FSCAN;
                    end
                end
                else if (uidx_reg >= UCW'(USED_SLOTS))
                begin
                    res_next   = '{result_addr: '0, status: STAT_UNKNOWN};
                    state_next = S_DONE;
                end
            end

            // Walk the free segments in address order.
            S_FSCAN:
            begin
                vld_next  = (fidx_reg < fcnt_reg);
                fcur_next = fidx_reg[FIW-1:0];
                if (fidx_reg < fcnt_reg)
                begin
                    fidx_next = fidx_reg + FCW'(1);
                end
                if (vld_reg)
                begin
                    if (op_reg == REQ_ALLOC)
                    begin
                        if (CW'(need_reg) <= d_size)
                        begin
                            seg_idx_next   = FCW'(fcur_reg);
                            seg_start_next = f_rdata[2*ADDR_BITS:SW];
                            seg_size_next  = f_rdata[SW-1:0];
                            uidx_next      = '0;
                            vld_next       = 1'b0;
                            state_next     = S_UVSCAN;
                        end
                    end
                    else if (d_end == CW'(ch_start_reg))
                    begin
                        // Chunk follows this segment: extend it.
                        f_we       = 1'b1;
                        f_waddr    = fcur_reg;
                        f_wdata    = {f_rdata[2*ADDR_BITS:SW], SW'(d_size + CW'(ch_size_reg))};
                        clr_v      = 1'b1;
                        res_next   = '{result_addr: '0, status: STAT_OK};
                        vld_next   = 1'b0;
                        state_next = S_DONE;
                    end
                    else if (ch_end == d_start)
                    begin
                        // Chunk precedes this segment: move its start down.
                        f_we       = 1'b1;
                        f_waddr    = fcur_reg;
                        f_wdata    = {ch_start_reg, SW'(d_size + CW'(ch_size_reg))};
                        clr_v      = 1'b1;
                        res_next   = '{result_addr: '0, status: STAT_OK};
                        vld_next   = 1'b0;
                        state_next = S_DONE;
                    end
                    else if (ch_end < d_start)
                    begin
                        seg_idx_next = FCW'(fcur_reg);
                        vld_next     = 1'b0;
                        state_next   = S_FINS;
                    end
                end
                else if (fidx_reg >= fcnt_reg)
                begin
                    if (op_reg == REQ_ALLOC)
                    begin
                        res_next   = '{result_addr: '0, status: STAT_NOFIT};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        seg_idx_next = fcnt_reg;
                        state_next   = S_FINS;
                    end
                end
            end

            // A new segment needs a free slot in the table.
            S_FINS:
            begin
                if (fcnt_reg >= FCW'(FREE_SLOTS))
                begin
                    res_next   = '{result_addr: '0, status: STAT_FULL};
                    state_next = S_DONE;
                end
                else
                begin
                    sidx_next  = fcnt_reg;
                    wpend_next = 1'b0;
                    state_next = S_SHUP;
                end
            end

            // Move entries up by one, from the tail down to the insert point.
            S_SHUP:
            begin
                if (wpend_reg)
                begin
                    f_we = 1'b1;
                end
                if (sidx_reg > seg_idx_reg)
                begin
                    f_raddr    = sidx_dec[FIW-1:0];
                    wtgt_next  = sidx_reg[FIW-1:0];
                    wpend_next = 1'b1;
                    sidx_next  = sidx_dec;
                end
                else
                begin
                    wpend_next = 1'b0;
                    state_next = S_INS;
                end
            end

            S_INS:
            begin
                f_we       = 1'b1;
                f_waddr    = seg_idx_reg[FIW-1:0];
                f_wdata    = {ch_start_reg, ch_size_reg};
                fcnt_next  = fcnt_reg + FCW'(1);
                clr_v      = 1'b1;
                res_next   = '{result_addr: '0, status: STAT_OK};
                state_next = S_DONE;
            end

            // Find the first idle slot of the used table.
            S_UVSCAN:
            begin
                if (!uvalid_reg[uidx_reg[UIW-1:0]])
                begin
                    uslot_next = uidx_reg[UIW-1:0];
                    state_next = S_ACOM;
                end
                else if (uidx_reg == UCW'(USED_SLOTS - 1))
                begin
                    res_next   = '{result_addr: '0, status: STAT_FULL};
                    state_next = S_DONE;
                end
                else
                begin
                    uidx_next = uidx_reg + UCW'(1);
                end
            end

            // Cut the chunk from the segment tail or take the whole segment.
            S_ACOM:
            begin
                if (left >= CW'(SPLIT_MIN))
                begin
                    f_we          = 1'b1;
                    f_waddr       = seg_idx_reg[FIW-1:0];
                    f_wdata       = {seg_start_reg, left[SW-1:0]};
                    ch_start_next = ADDR_BITS'(CW'(seg_start_reg) + left);
                    ch_size_next  = SW'(need_reg);
                    state_next    = S_AFIN;
                end
                else
                begin
                    ch_start_next = seg_start_reg;
                    ch_size_next  = seg_size_reg;
                    sidx_next     = seg_idx_reg + FCW'(1);
                    wpend_next    = 1'b0;
                    state_next    = S_SHDN;
                end
            end

            // Close the gap left by a removed segment.
            S_SHDN:
            begin
                if (wpend_reg)
                begin
                    f_we = 1'b1;
                end
                if (sidx_reg < fcnt_reg)
                begin
                    f_raddr    = sidx_reg[FIW-1:0];
                    wtgt_next  = sidx_dec[FIW-1:0];
                    wpend_next = 1'b1;
                    sidx_next  = sidx_inc;
                end
                else
                begin
                    wpend_next = 1'b0;
                    fcnt_next  = fcnt_reg - FCW'(1);
                    state_next = S_AFIN;
                end
            end

            S_AFIN:
            begin
                u_we       = 1'b1;
                set_v      = 1'b1;
                res_next   = '{result_addr: ADDR_W'(CW'(ch_start_reg) + CW'(CHUNK_HDR)),
                               status: STAT_OK};
                state_next = S_DONE;
            end

            // Hand the result to the output register once it is free.
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_INIT;
            end
        endcase

        // A new arena size restarts with one free segment.
        if (cfg_we)
        begin
            state_next = S_INIT;
            fcnt_next  = FCW'(1);
        end
    end

    // The segment count never exceeds the table depth.
    a_fcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        fcnt_reg <= FCW'(FREE_SLOTS))
        else $error("free segment count beyond table depth");

    // Without a request in flight or a configuration write the table size holds.
    a_fcnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !cfg_we) |=> $stable(fcnt_reg))
        else $error("segment count changed while idle");

    // Shifting up only happens with room for one more segment.
    a_shup_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHUP) |-> (fcnt_reg < FCW'(FREE_SLOTS)))
        else $error("insert into a full segment table");

    // A failed request never reports an address.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.status != STAT_OK && rsp_reg.result_addr != '0) |-> 1'b0)
        else $error("address reported on a failed request");

endmodule

`default_nettype wire

// ===== rtl/core/first_fit_free_list_allocator_top.sv =====
// Top level of the first-fit free-list allocator: arena size register and tables.
// Depends on ffa_pkg, ffa_ram and ffa_ctrl.
//
//  Channel | Signals                     | Payload
//  --------+-----------------------------+-------------------------------------
//  cfg     | cfg_we, cfg_wdata           | arena size in bytes, no read-back
//  req     | req_valid, req_stall, req   | req_type, req_size, free_addr
//  rsp     | rsp_valid, rsp_stall, rsp   | result_addr, status
//
// One request is in flight at a time. An allocate walks k segments, searches
// u used slots and shifts s segments; a free looks up m used entries, walks k
// segments and shifts s segments. Each scan and shift moves one entry a cycle,
// paced by the single read port of each table.
// After reset and after each configuration write the S_INIT state seeds the table.
// A stalled result waits in the output register; the next request is taken
// while it waits.
`default_nettype none

module first_fit_free_list_allocator_top #(
    parameter int FREE_SLOTS = 64,
    parameter int USED_SLOTS = 64,
    parameter int ADDR_BITS  = 22
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [22:0]          cfg_wdata,
    input  wire logic                 req_valid,
    output logic                      req_stall,
    input  wire ffa_pkg::req_t        req,
    output logic                      rsp_valid,
    input  wire logic                 rsp_stall,
    output ffa_pkg::rsp_t             rsp
);

    import ffa_pkg::*;

    localparam int SW  = ADDR_BITS + 1;
    localparam int CW  = ((SW > CFG_W) ? SW : CFG_W) + 1;
    localparam int DW  = 2 * ADDR_BITS + 1;
    localparam int FIW = $clog2(FREE_SLOTS);
    localparam int UIW = $clog2(USED_SLOTS);
    localparam logic [CW-1:0] ARENA_MAX = CW'(1) << ADDR_BITS;
    localparam logic [CW-1:0] ARENA_RST =
        (CW'(ARENA_RESET) > ARENA_MAX) ? ARENA_MAX : CW'(ARENA_RESET);

    logic [SW-1:0]  arena_reg, arena_next;
    logic [CW-1:0]  cfg_ext;
    logic           f_we, u_we;
    logic [FIW-1:0] f_waddr, f_raddr;
    logic [UIW-1:0] u_waddr, u_raddr;
    logic [DW-1:0]  f_wdata, f_rdata, u_wdata, u_rdata;

    // Clamp the written arena size to the legal range.
    assign cfg_ext = CW'(cfg_wdata);
    always_comb
    begin
        if (cfg_ext < CW'(ARENA_MIN))
        begin
            arena_next = SW'(ARENA_MIN);
        end
        else if (cfg_ext > ARENA_MAX)
        begin
            arena_next = SW'(ARENA_MAX);
        end
        else
        begin
            arena_next = SW'(cfg_ext);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arena_reg <= SW'(ARENA_RST);
        end
        else if (cfg_we)
        begin
            arena_reg <= arena_next;
        end
    end

    // Free segment table: start and size, in address order.
    ffa_ram #(.DEPTH(FREE_SLOTS), .DW(DW)) u_free_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    // Used chunk table: start and size of each live chunk.
    ffa_ram #(.DEPTH(USED_SLOTS), .DW(DW)) u_used_ram (
        .clk   (clk),
        .we    (u_we),
        .waddr (u_waddr),
        .wdata (u_wdata),
        .raddr (u_raddr),
        .rdata (u_rdata)
    );

    ffa_ctrl #(
        .FREE_SLOTS (FREE_SLOTS),
        .USED_SLOTS (USED_SLOTS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .arena     (arena_reg),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .f_we      (f_we),
        .f_waddr   (f_waddr),
        .f_wdata   (f_wdata),
        .f_raddr   (f_raddr),
        .f_rdata   (f_rdata),
        .u_we      (u_we),
        .u_waddr   (u_waddr),
        .u_wdata   (u_wdata),
        .u_raddr   (u_raddr),
        .u_rdata   (u_rdata)
    );

endmodule

`default_nettype wire
